// ===== sv/quadratic_root_solver_core_macros.svh =====
// assertion macros shared by the solver modules
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define QRS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked out of reset
`define QRS_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/qrs_pkg.sv =====
// shared types, constants and helpers of the quadratic root solver
package qrs_pkg;

  localparam int QDEPTH = 4;  // power of two, pointers wrap naturally
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 32;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_TOL = 1'b1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_LINEAR,
    KIND_DOUBLE,
    KIND_TWO
  } kind_t;

  // disc holds 33 digit pairs for the square root
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [65:0]        disc;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// ===== sv/qrs_front.sv =====
// front end: tolerance registers, products, discriminant and case selection
module qrs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [95:0]                    s_tdata,
  input  qrs_pkg::qstat_t                qstat,
  output logic                           push,
  output qrs_pkg::item_t                 push_item
);
  import qrs_pkg::*;

  logic [15:0] coef_tol;
  logic [31:0] disc_tol;

  logic               v1;
  logic signed [31:0] a1, b1, c1;
  logic signed [63:0] bb1, ac1;
  logic               za1, zb1, zc1;

  logic signed [31:0] a_in, b_in, c_in;
  logic               accept;
  logic signed [66:0] d;
  logic [66:0]        dmag;
  logic               dzero, dpos;

  function automatic logic coef_zero(logic signed [31:0] v, logic [15:0] tol);
    logic [31:0] m;
    m = mag32(v);
    coef_zero = (m == 32'd0) || (m < {16'd0, tol});
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_tol <= 16'd1;
      disc_tol <= 32'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COEF_TOL: coef_tol <= cfg_data[15:0];
        CFG_DISC_TOL: disc_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // credit: the accepted item and the one in flight must both fit
  assign s_tready = ({1'b0, qstat.count} + (QCNT_W+1)'(v1)) < (QCNT_W+1)'(QDEPTH);
  assign accept   = s_tvalid && s_tready;

  assign a_in = s_tdata[31:0];
  assign b_in = s_tdata[63:32];
  assign c_in = s_tdata[95:64];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a1  <= a_in;
      b1  <= b_in;
      c1  <= c_in;
      bb1 <= b_in * b_in;
      ac1 <= a_in * c_in;
      za1 <= coef_zero(a_in, coef_tol);
      zb1 <= coef_zero(b_in, coef_tol);
      zc1 <= coef_zero(c_in, coef_tol);
    end
  end

  // exact discriminant b*b - 4*a*c
  assign d     = $signed({{3{bb1[63]}}, bb1}) - $signed({ac1[63], ac1, 2'b00});
  assign dmag  = d[66] ? 67'(-d) : d;
  assign dzero = (d == 67'sd0) || (dmag < {35'd0, disc_tol});
  assign dpos  = !d[66] && (d != 67'sd0);

  always_comb begin
    push_item.a    = a1;
    push_item.b    = b1;
    push_item.c    = c1;
    push_item.disc = d[65:0];
    if (za1) begin
      if (zb1 && zc1)  push_item.kind = KIND_ALL;
      else if (zb1)    push_item.kind = KIND_NONE;
      else             push_item.kind = KIND_LINEAR;
    end else begin
      if (dzero)       push_item.kind = KIND_DOUBLE;
      else if (dpos)   push_item.kind = KIND_TWO;
      else             push_item.kind = KIND_NONE;
    end
  end

  assign push = v1;

endmodule

// ===== sv/qrs_queue.sv =====
// short queue between front and back
module qrs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qrs_pkg::item_t  push_item,
  input  logic            pop,
  output qrs_pkg::item_t  head,
  output qrs_pkg::qstat_t qstat
);
  import qrs_pkg::*;

  item_t             ents [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ents[wr_ptr] <= push_item;
  end

  assign head        = ents[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

  `include "quadratic_root_solver_core_macros.svh"

  `QRS_ASSERT_IMP(a_no_overflow, push && !pop, count != QCNT_W'(QDEPTH), "queue overflow")
  `QRS_ASSERT_IMP(a_no_underflow, pop, count != '0, "queue underflow")

endmodule

// ===== sv/qrs_back.sv =====
// back end: pipelined square root, two pipelined dividers, clipping, output register
module qrs_back (
  input  logic            clk,
  input  logic            rst,
  input  qrs_pkg::item_t  head,
  input  qrs_pkg::qstat_t qstat,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [71:0]     m_tdata
);
  import qrs_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [65:0]        disc;
    logic [32:0]        root;
    logic [34:0]        rem;
  } sq_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [50:0] n1;
    logic signed [50:0] n2;
    logic signed [31:0] den;
  } nm_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] m;
    logic [49:0] r1;
    logic [49:0] r2;
    logic        neg1;
    logic        neg2;
    logic        big1;
    logic        big2;
    logic [31:0] q1;
    logic [31:0] q2;
  } dv_t;

  logic en;

  sq_t                 sq   [SQRT_STEPS+1];
  logic [SQRT_STEPS:0] sq_v;
  nm_t                 nm;
  logic                nm_v;
  dv_t                 dv   [DIV_STEPS+1];
  logic [DIV_STEPS:0]  dv_v;

  logic [1:0]  count;
  logic [31:0] r1, r2;
  logic        sat;

  // whole back pipeline moves together when the output slot can take a beat
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= !qstat.empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].kind <= head.kind;
      sq[0].a    <= head.a;
      sq[0].b    <= head.b;
      sq[0].c    <= head.c;
      sq[0].disc <= head.disc;
      sq[0].root <= '0;
      sq[0].rem  <= '0;
    end
  end

  // one root bit per stage, most significant digit pair first
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int I = SQRT_STEPS - 1 - j;
    logic [36:0] cat, trial;
    logic        ge;
    assign cat   = {sq[j].rem, sq[j].disc[2*I+1 -: 2]};
    assign trial = {2'b00, sq[j].root, 2'b01};
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[j+1].kind <= sq[j].kind;
        sq[j+1].a    <= sq[j].a;
        sq[j+1].b    <= sq[j].b;
        sq[j+1].c    <= sq[j].c;
        sq[j+1].disc <= sq[j].disc;
        sq[j+1].root <= {sq[j].root[31:0], ge};
        sq[j+1].rem  <= ge ? 35'(cat - trial) : cat[34:0];
      end
    end
  end

  // numerators in Q16.16 times divisor scale
  logic signed [50:0] bx, cx, sx;
  assign bx = 51'(sq[SQRT_STEPS].b);
  assign cx = 51'(sq[SQRT_STEPS].c);
  assign sx = $signed({18'd0, sq[SQRT_STEPS].root});

  always_ff @(posedge clk) begin
    if (rst) nm_v <= 1'b0;
    else if (en) nm_v <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm.kind <= sq[SQRT_STEPS].kind;
      case (sq[SQRT_STEPS].kind)
        KIND_LINEAR: begin
          nm.n1  <= (-cx) <<< 16;
          nm.n2  <= (-cx) <<< 16;
          nm.den <= sq[SQRT_STEPS].b;
        end
        KIND_DOUBLE: begin
          nm.n1  <= (-bx) <<< 15;
          nm.n2  <= (-bx) <<< 15;
          nm.den <= sq[SQRT_STEPS].a;
        end
        default: begin
          nm.n1  <= (sx - bx) <<< 15;
          nm.n2  <= (-bx - sx) <<< 15;
          nm.den <= sq[SQRT_STEPS].a;
        end
      endcase
    end
  end

  // magnitudes, signs and early overflow check
  logic [49:0] n1m, n2m;
  logic [31:0] dm;
  assign n1m = nm.n1[50] ? 50'(-nm.n1) : nm.n1[49:0];
  assign n2m = nm.n2[50] ? 50'(-nm.n2) : nm.n2[49:0];
  assign dm  = mag32(nm.den);

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= nm_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].kind <= nm.kind;
      dv[0].m    <= dm;
      dv[0].r1   <= n1m;
      dv[0].r2   <= n2m;
      dv[0].neg1 <= nm.n1[50] ^ nm.den[31];
      dv[0].neg2 <= nm.n2[50] ^ nm.den[31];
      dv[0].big1 <= {14'd0, n1m} >= {dm, 32'd0};
      dv[0].big2 <= {14'd0, n2m} >= {dm, 32'd0};
      dv[0].q1   <= '0;
      dv[0].q2   <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [63:0] sh;
    logic        ge1, ge2;
    assign sh  = {32'd0, dv[j].m} << K;
    assign ge1 = {14'd0, dv[j].r1} >= sh;
    assign ge2 = {14'd0, dv[j].r2} >= sh;

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1].kind <= dv[j].kind;
        dv[j+1].m    <= dv[j].m;
        dv[j+1].neg1 <= dv[j].neg1;
        dv[j+1].neg2 <= dv[j].neg2;
        dv[j+1].big1 <= dv[j].big1;
        dv[j+1].big2 <= dv[j].big2;
        dv[j+1].r1   <= ge1 ? 50'({14'd0, dv[j].r1} - sh) : dv[j].r1;
        dv[j+1].r2   <= ge2 ? 50'({14'd0, dv[j].r2} - sh) : dv[j].r2;
        dv[j+1].q1   <= {dv[j].q1[30:0], ge1};
        dv[j+1].q2   <= {dv[j].q2[30:0], ge2};
      end
    end
  end

  // returns {clipped, value}
  function automatic logic [32:0] clip(logic [31:0] q, logic neg, logic big);
    if (big)           clip = {1'b1, neg ? Q_MIN : Q_MAX};
    else if (!neg)     clip = q[31] ? {1'b1, Q_MAX} : {1'b0, q};
    else if (q > Q_MIN) clip = {1'b1, Q_MIN};
    else               clip = {1'b0, 32'(-q)};
  endfunction

  logic [32:0] c1, c2;
  dv_t         fin;
  assign fin = dv[DIV_STEPS];
  assign c1  = clip(fin.q1, fin.neg1, fin.big1);
  assign c2  = clip(fin.q2, fin.neg2, fin.big2);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv_v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (fin.kind)
        KIND_LINEAR, KIND_DOUBLE: begin
          count <= CNT_ONE;
          r1    <= c1[31:0];
          r2    <= c1[31:0];
          sat   <= c1[32];
        end
        KIND_TWO: begin
          count <= CNT_TWO;
          r1    <= c1[31:0];
          r2    <= c2[31:0];
          sat   <= c1[32] | c2[32];
        end
        KIND_ALL: begin
          count <= CNT_ALL;
          r1    <= '0;
          r2    <= '0;
          sat   <= 1'b0;
        end
        default: begin
          count <= CNT_NONE;
          r1    <= '0;
          r2    <= '0;
          sat   <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {5'd0, sat, r2, r1, count};

  logic rootless, clean_out;
  assign rootless  = (count == CNT_NONE) || (count == CNT_ALL);
  assign clean_out = (r1 == '0) && (r2 == '0) && !sat;

  `include "quadratic_root_solver_core_macros.svh"

  `QRS_ASSERT_IMP(a_no_root_clean, m_tvalid && rootless, clean_out, "rootless beat has data")
  `QRS_ASSERT_IMP(a_single_root_same, m_tvalid && count == CNT_ONE, r1 == r2, "roots differ")
  `QRS_ASSERT_NXT(a_pop_enters_pipe, pop, sq_v[0], "popped item lost")

endmodule

// ===== sv/quadratic_root_solver_core.sv =====
// top level of the quadratic root solver
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  s       | in        | s_tvalid/s_tready    | s_tdata: coef_quad, coef_lin, coef_const
//  m       | out       | m_tvalid/m_tready    | m_tdata: root_count, roots, saturated
//
// one item per cycle sustained while m does not stall; the result beat passes through the
// front register, the queue, the square-root entry register, the 33-stage square root,
// the numerator stage, the magnitude stage, the 32-stage dividers and the output register
// reset clears all valid bits and sets both tolerances to 1
// a stall on m stops the back pipeline; the front keeps accepting until the
// queue has no room left, then drops s_tready
module quadratic_root_solver_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,  // coef_quad, coef_lin, coef_const
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata   // root_count, root_first, root_second,
                                                  // saturated, zero pad
);
  import qrs_pkg::*;

  logic   push, pop;
  item_t  push_item, head;
  qstat_t qstat;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  qrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  qrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
